### hdl/shape_overlap_test_macros.svh
// assertion helpers for the checked modules, included by sot_queue
`ifndef SHAPE_OVERLAP_TEST_MACROS_SVH
`define SHAPE_OVERLAP_TEST_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define SOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define SOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sot_pkg.sv
package sot_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NLANE          = 8;
    localparam int QUEUE_DEPTH    = 2;

    // pair classification codes
    localparam logic [1:0] PAIR_RR = 2'd0;
    localparam logic [1:0] PAIR_ER = 2'd1;
    localparam logic [1:0] PAIR_EE = 2'd2;

    typedef struct packed {
        logic [1:0]       pair;
        logic             early;
        logic             sized_ok;
        logic [NLANE-1:0] lane_en;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

endpackage

### hdl/sot_front.sv
module sot_front
    import sot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          first_kind,
    input  logic signed [COORD_BITS-1:0]  first_left,
    input  logic signed [COORD_BITS-1:0]  first_top,
    input  logic signed [COORD_BITS-1:0]  first_right,
    input  logic signed [COORD_BITS-1:0]  first_bottom,
    input  logic                          second_kind,
    input  logic signed [COORD_BITS-1:0]  second_left,
    input  logic signed [COORD_BITS-1:0]  second_top,
    input  logic signed [COORD_BITS-1:0]  second_right,
    input  logic signed [COORD_BITS-1:0]  second_bottom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ctl_t                          out_ctl,
    output logic [NLANE*(5*COORD_BITS+3)-1:0] out_lanes
);

    localparam int C      = COORD_BITS;
    localparam int LANE_W = 5*C+3;

    function automatic logic signed [C:0] ext(input logic signed [C-1:0] v);
        return (C+1)'(v);
    endfunction

    function automatic logic signed [C:0] dbl(input logic signed [C-1:0] v);
        return $signed({v, 1'b0});
    endfunction

    function automatic logic [C:0] absdiff(input logic signed [C:0] a,
                                           input logic signed [C:0] b);
        logic signed [C+1:0] d;
        d = (C+2)'(a) - (C+2)'(b);
        return (d < 0) ? (C+1)'(-d) : (C+1)'(d);
    endfunction

    logic signed [C:0] cx1, cy1, w1, h1, cx2, cy2, w2, h2;
    logic signed [C:0] ecx, ecy, we, he, rl, rt, rr, rb;
    logic              e_ok, c_in, ex_en, ey_en, rr_hit, all_ok;
    logic signed [C-1:0] max_l, min_r, max_t, min_b;
    logic signed [C:0] px [NLANE];
    logic signed [C:0] py [NLANE];
    logic [C:0]   lx [NLANE];
    logic [C:0]   ly [NLANE];
    logic [C-1:0] lw [NLANE];
    logic [C-1:0] lh [NLANE];
    logic [C:0]   ls [NLANE];
    logic [NLANE-1:0] er_en;
    ctl_t              ctl_next;
    logic [NLANE*LANE_W-1:0] lanes_next;

    logic              out_valid_reg;
    ctl_t              ctl_reg;
    logic [NLANE*LANE_W-1:0] lanes_reg;

    always_comb begin
        cx1 = ext(first_left) + ext(first_right);
        cy1 = ext(first_top) + ext(first_bottom);
        w1  = ext(first_right) - ext(first_left);
        h1  = ext(first_bottom) - ext(first_top);
        cx2 = ext(second_left) + ext(second_right);
        cy2 = ext(second_top) + ext(second_bottom);
        w2  = ext(second_right) - ext(second_left);
        h2  = ext(second_bottom) - ext(second_top);

        ecx = first_kind ? cx1 : cx2;
        ecy = first_kind ? cy1 : cy2;
        we  = first_kind ? w1 : w2;
        he  = first_kind ? h1 : h2;
        rl  = first_kind ? dbl(second_left)   : dbl(first_left);
        rt  = first_kind ? dbl(second_top)    : dbl(first_top);
        rr  = first_kind ? dbl(second_right)  : dbl(first_right);
        rb  = first_kind ? dbl(second_bottom) : dbl(first_bottom);

        e_ok  = (we > 0) && (he > 0);
        c_in  = (ecx >= rl) && (ecx <= rr) && (ecy >= rt) && (ecy <= rb);
        ex_en = (ecx > rl) && (ecx <= rr);
        ey_en = (ecy > rt) && (ecy <= rb);

        max_l  = (first_left > second_left)     ? first_left   : second_left;
        min_r  = (first_right < second_right)   ? first_right  : second_right;
        max_t  = (first_top > second_top)       ? first_top    : second_top;
        min_b  = (first_bottom < second_bottom) ? first_bottom : second_bottom;
        rr_hit = (min_r > max_l) && (min_b > max_t);

        all_ok = (w1 > 0) && (h1 > 0) && (w2 > 0) && (h2 > 0);

        // edge points level with the ellipse center, then corners of the rectangle
        px[0] = ecx; py[0] = rt;
        px[1] = ecx; py[1] = rb;
        px[2] = rl;  py[2] = ecy;
        px[3] = rr;  py[3] = ecy;
        px[4] = rl;  py[4] = rt;
        px[5] = rl;  py[5] = rb;
        px[6] = rr;  py[6] = rt;
        px[7] = rr;  py[7] = rb;
        er_en = {4'b1111, ey_en, ey_en, ex_en, ex_en} & {NLANE{e_ok}};

        for (int k = 0; k < NLANE; k++) begin
            lx[k] = absdiff(px[k], ecx);
            ly[k] = absdiff(py[k], ecy);
            lw[k] = we[C-1:0];
            lh[k] = he[C-1:0];
            ls[k] = {1'b0, we[C-1:0]};
        end

        ctl_next.early    = 1'b0;
        ctl_next.sized_ok = all_ok;
        ctl_next.lane_en  = '0;
        if (first_kind && second_kind) begin
            ctl_next.pair = PAIR_EE;
            // first ellipse holds second center, second holds first, distance bound
            for (int k = 0; k < 3; k++) begin
                lx[k] = absdiff(cx2, cx1);
                ly[k] = absdiff(cy2, cy1);
            end
            lw[0] = w1[C-1:0]; lh[0] = h1[C-1:0]; ls[0] = {1'b0, w1[C-1:0]};
            lw[1] = w2[C-1:0]; lh[1] = h2[C-1:0]; ls[1] = {1'b0, w2[C-1:0]};
            lw[2] = w2[C-1:0]; lh[2] = h2[C-1:0];
            ls[2] = (C+1)'(w1[C-1:0]) + (C+1)'(w2[C-1:0]);
            ctl_next.lane_en[0] = (w1 > 0) && (h1 > 0);
            ctl_next.lane_en[1] = (w2 > 0) && (h2 > 0);
            ctl_next.lane_en[2] = all_ok;
        end else if (first_kind || second_kind) begin
            ctl_next.pair    = PAIR_ER;
            ctl_next.early   = c_in;
            ctl_next.lane_en = er_en;
        end else begin
            ctl_next.pair  = PAIR_RR;
            ctl_next.early = rr_hit;
        end

        for (int k = 0; k < NLANE; k++) begin
            lanes_next[k*LANE_W +: LANE_W] = {lx[k], ly[k], lw[k], lh[k], ls[k]};
        end
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ctl_reg   <= ctl_next;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_lanes = lanes_reg;

endmodule

### hdl/sot_queue.sv
`include "shape_overlap_test_macros.svh"

module sot_queue
    import sot_pkg::*;
#(
    parameter int WIDTH = CTL_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg != CNT_W'(DEPTH)) || pop;
    assign push      = in_valid && in_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    `SOT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `SOT_ASSERT_NEXT(a_full_holds, aclk, aresetn, (count_reg == CNT_W'(DEPTH)) && !out_ready, count_reg == CNT_W'(DEPTH), "full queue lost an entry")
    `SOT_ASSERT_NEXT(a_empty_push, aclk, aresetn, (count_reg == '0) && in_valid, out_valid, "pushed entry not visible")

endmodule

### hdl/sot_lane.sv
module sot_lane
    import sot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic [COORD_BITS:0]   x,
    input  logic [COORD_BITS:0]   y,
    input  logic [COORD_BITS-1:0] w,
    input  logic [COORD_BITS-1:0] h,
    input  logic [COORD_BITS:0]   s,
    output logic                  le
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2*C+1;
    localparam int QW = 2*PW;

    logic [PW-1:0] xh_reg, yw_reg, sh_reg;
    logic [QW-1:0] xx_reg, yy_reg, ss_reg;

    // (x*h)^2 + (y*w)^2 <= (s*h)^2
    always_ff @(posedge aclk) begin
        if (adv) begin
            xh_reg <= PW'(x) * PW'(h);
            yw_reg <= PW'(y) * PW'(w);
            sh_reg <= PW'(s) * PW'(h);
            xx_reg <= QW'(xh_reg) * QW'(xh_reg);
            yy_reg <= QW'(yw_reg) * QW'(yw_reg);
            ss_reg <= QW'(sh_reg) * QW'(sh_reg);
        end
    end

    assign le = ((QW+1)'(xx_reg) + (QW+1)'(yy_reg)) <= (QW+1)'(ss_reg);

endmodule

### hdl/sot_back.sv
module sot_back
    import sot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ctl_t                          in_ctl,
    input  logic [NLANE*(5*COORD_BITS+3)-1:0] in_lanes,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_overlaps,
    output logic                          out_undecided
);

    localparam int C      = COORD_BITS;
    localparam int LANE_W = 5*C+3;

    logic             adv;
    logic             v1_reg, v2_reg, out_valid_reg;
    ctl_t             ctl1_reg, ctl2_reg;
    logic [2*C-1:0]   ra_reg, rb_reg;
    logic             ne_reg;
    logic [NLANE-1:0] le, hit;
    logic             ov_reg, und_reg, ov_next, und_next;
    logic [C-1:0]     w0, h0, w1, h1;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    for (genvar k = 0; k < NLANE; k++) begin : g_lane
        sot_lane #(.COORD_BITS(C)) u_lane (
            .aclk (aclk),
            .adv  (adv),
            .x    (in_lanes[k*LANE_W + 4*C+2 +: C+1]),
            .y    (in_lanes[k*LANE_W + 3*C+1 +: C+1]),
            .w    (in_lanes[k*LANE_W + 2*C+1 +: C]),
            .h    (in_lanes[k*LANE_W + C+1   +: C]),
            .s    (in_lanes[k*LANE_W         +: C+1]),
            .le   (le[k])
        );
    end

    assign w0 = in_lanes[2*C+1 +: C];
    assign h0 = in_lanes[C+1 +: C];
    assign w1 = in_lanes[LANE_W + 2*C+1 +: C];
    assign h1 = in_lanes[LANE_W + C+1 +: C];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // aspect ratio cross products ride alongside the lanes
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ra_reg   <= (2*C)'(w1) * (2*C)'(h0);
            rb_reg   <= (2*C)'(w0) * (2*C)'(h1);
            ne_reg   <= (ra_reg != rb_reg);
            ov_reg   <= ov_next;
            und_reg  <= und_next;
        end
    end

    always_comb begin
        hit      = le & ctl2_reg.lane_en;
        ov_next  = 1'b0;
        und_next = 1'b0;
        unique case (ctl2_reg.pair)
            PAIR_RR: ov_next = ctl2_reg.early;
            PAIR_ER: ov_next = ctl2_reg.early || (|hit);
            PAIR_EE: begin
                if (hit[0] || hit[1]) begin
                    ov_next = 1'b1;
                end else if (!ctl2_reg.sized_ok) begin
                    ov_next = 1'b0;
                end else if (ne_reg) begin
                    und_next = 1'b1;
                end else begin
                    ov_next = hit[2];
                end
            end
            default: ov_next = 1'b0;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_overlaps  = ov_reg;
    assign out_undecided = und_reg;

endmodule

### hdl/shape_overlap_test.sv
// shape_overlap_test: area overlap of two axis-aligned shapes
// input channel s_*: one request per pair; each shape is a rectangle or an
//   ellipse inscribed in its bounding box (kind 0 rectangle, 1 ellipse)
// result channel m_*: m_overlaps is 1 when the areas intersect, m_undecided
//   is 1 for two ellipses of unequal aspect ratio that no test could settle
// throughput: one request per cycle sustained while m_ready stays high, set by
//   the fully pipelined multiplier lanes in the back end
// registers from acceptance to m_valid: front register, queue, two multiplier
//   stages, then the result register
// a front stage classifies the pair and forms lane operands; a two-entry
//   queue separates it from the back end, which evaluates up to eight
//   ellipse containment tests in parallel lanes
// reset (aresetn low, synchronous) empties every stage and the queue
// when the receiver stalls, the back end holds; the two queue entries and
//   the front register then hold up to three waiting requests before s_ready drops
module shape_overlap_test
    import sot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_first_kind,
    input  logic signed [COORD_BITS-1:0] s_first_left,
    input  logic signed [COORD_BITS-1:0] s_first_top,
    input  logic signed [COORD_BITS-1:0] s_first_right,
    input  logic signed [COORD_BITS-1:0] s_first_bottom,
    input  logic                         s_second_kind,
    input  logic signed [COORD_BITS-1:0] s_second_left,
    input  logic signed [COORD_BITS-1:0] s_second_top,
    input  logic signed [COORD_BITS-1:0] s_second_right,
    input  logic signed [COORD_BITS-1:0] s_second_bottom,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_overlaps,
    output logic                         m_undecided
);

    localparam int LANES_W = NLANE*(5*COORD_BITS+3);
    localparam int Q_W     = CTL_W + LANES_W;

    // front to queue
    logic               f_valid, f_ready;
    ctl_t               f_ctl;
    logic [LANES_W-1:0] f_lanes;

    // queue to back
    logic               b_valid, b_ready;
    logic [Q_W-1:0]     b_data;
    ctl_t               b_ctl;

    sot_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .first_kind    (s_first_kind),
        .first_left    (s_first_left),
        .first_top     (s_first_top),
        .first_right   (s_first_right),
        .first_bottom  (s_first_bottom),
        .second_kind   (s_second_kind),
        .second_left   (s_second_left),
        .second_top    (s_second_top),
        .second_right  (s_second_right),
        .second_bottom (s_second_bottom),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_ctl       (f_ctl),
        .out_lanes     (f_lanes)
    );

    // classified requests wait here while the back end is stalled
    sot_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_lanes}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign b_ctl = b_data[Q_W-1 -: CTL_W];

    sot_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (b_valid),
        .in_ready      (b_ready),
        .in_ctl        (b_ctl),
        .in_lanes      (b_data[LANES_W-1:0]),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_overlaps  (m_overlaps),
        .out_undecided (m_undecided)
    );

endmodule

### tb/sv/shape_overlap_test_test.sv
`timescale 1ns / 100ps

module shape_overlap_test_test;
    import sot_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    // shape kinds
    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_ELL  = 1'b1;

    typedef struct {
        logic         kind;
        longint       l, t, r, b;
    } shape_t;

    typedef struct {
        logic ovl;
        logic und;
    } verdict_t;

    // verdict codes of one direction of the test
    typedef enum int {V_NO, V_YES, V_OPEN} probe_e;

    // ---------------------------------------------------------------
    // overlap predictor, exact integer math on doubled coordinates
    // ---------------------------------------------------------------
    function automatic bit box_holds(shape_t s, longint px, longint py);
        return px >= 2 * s.l && px <= 2 * s.r && py >= 2 * s.t && py <= 2 * s.b;
    endfunction

    function automatic bit ell_holds(shape_t s, longint px, longint py);
        longint w, h;
        logic [127:0] dx2, dy2, lhs, rhs;
        w = s.r - s.l;
        h = s.b - s.t;
        if (w <= 0 || h <= 0) return 0;
        dx2 = (px - (s.l + s.r)) * (px - (s.l + s.r));
        dy2 = (py - (s.t + s.b)) * (py - (s.t + s.b));
        lhs = dx2 * (h * h) + dy2 * (w * w);
        rhs = 128'(w * w) * 128'(h * h);
        return lhs <= rhs;
    endfunction

    function automatic probe_e ell_box(shape_t e, shape_t r);
        longint cx, cy;
        cx = e.l + e.r;
        cy = e.t + e.b;
        if (box_holds(r, cx, cy)) return V_YES;
        if (cx > 2 * r.l && cx <= 2 * r.r &&
            (ell_holds(e, cx, 2 * r.t) || ell_holds(e, cx, 2 * r.b))) return V_YES;
        if (cy > 2 * r.t && cy <= 2 * r.b &&
            (ell_holds(e, 2 * r.l, cy) || ell_holds(e, 2 * r.r, cy))) return V_YES;
        if (ell_holds(e, 2 * r.l, 2 * r.t) || ell_holds(e, 2 * r.l, 2 * r.b) ||
            ell_holds(e, 2 * r.r, 2 * r.t) || ell_holds(e, 2 * r.r, 2 * r.b))
            return V_YES;
        return V_NO;
    endfunction

    function automatic probe_e ell_ell(shape_t a, shape_t o);
        longint w1, h1, w2, h2, dx, dy;
        logic [127:0] lhs, rhs;
        w1 = o.r - o.l; h1 = o.b - o.t;
        w2 = a.r - a.l; h2 = a.b - a.t;
        if (ell_holds(a, o.l + o.r, o.t + o.b) || ell_holds(o, a.l + a.r, a.t + a.b))
            return V_YES;
        if (w1 <= 0 || w2 <= 0 || h1 <= 0 || h2 <= 0) return V_NO;
        if (w1 * h2 != w2 * h1) return V_OPEN;
        dx = (o.l + o.r) - (a.l + a.r);
        dy = (o.t + o.b) - (a.t + a.b);
        lhs = 128'(dx * dx) * 128'(h1 * h1) + 128'(dy * dy) * 128'(w1 * w1);
        rhs = 128'((w1 + w2) * (w1 + w2)) * 128'(h1 * h1);
        return (lhs <= rhs) ? V_YES : V_NO;
    endfunction

    function automatic probe_e one_way(shape_t me, shape_t ot);
        longint l, r, t, b;
        if (me.kind == KIND_RECT) begin
            if (ot.kind != KIND_RECT) return V_OPEN;
            l = (me.l > ot.l) ? me.l : ot.l;
            r = (me.r < ot.r) ? me.r : ot.r;
            t = (me.t > ot.t) ? me.t : ot.t;
            b = (me.b < ot.b) ? me.b : ot.b;
            return (r - l <= 0 || b - t <= 0) ? V_NO : V_YES;
        end
        if (ot.kind != KIND_RECT) return ell_ell(me, ot);
        return ell_box(me, ot);
    endfunction

    function automatic verdict_t predict_overlap(shape_t a, shape_t b);
        probe_e p;
        verdict_t v;
        p = one_way(a, b);
        if (p == V_OPEN) p = one_way(b, a);
        v.ovl = (p == V_YES);
        v.und = (p == V_OPEN);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard: expected verdicts in acceptance order
    // ---------------------------------------------------------------
    class verdict_board;
        verdict_t pending[$];
        int errors;

        function void note_request(shape_t a, shape_t b);
            pending.push_back(predict_overlap(a, b));
        endfunction

        function void check_verdict(logic ovl, logic und);
            verdict_t e;
            if (pending.size() == 0) begin
                $error("unexpected result overlaps=%0b undecided=%0b", ovl, und);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ovl !== e.ovl) begin
                $error("overlaps: expected %0b actual %0b", e.ovl, ovl);
                errors++;
            end
            if (und !== e.und) begin
                $error("undecided: expected %0b actual %0b", e.und, und);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_overlaps, m_undecided;
    logic s_first_kind, s_second_kind;
    logic signed [CB-1:0] s_first_left, s_first_top, s_first_right, s_first_bottom;
    logic signed [CB-1:0] s_second_left, s_second_top, s_second_right, s_second_bottom;

    shape_overlap_test u_dut (.*);

    verdict_board board = new();
    int send_idle_pct = 0;     // chance of a sender gap, per cycle
    int recv_stall_pct = 0;    // chance of a receiver stall, per cycle
    bit hold_off = 0;          // long receiver hold-off in progress
    int quiet_cycles = 0;

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // record accepted requests and check results at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_request(
                    '{s_first_kind, s_first_left, s_first_top, s_first_right, s_first_bottom},
                    '{s_second_kind, s_second_left, s_second_top, s_second_right,
                      s_second_bottom});
            if (m_valid && m_ready) board.check_verdict(m_overlaps, m_undecided);
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a full stop during the hold-off
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // random coordinate, biased toward small shapes near the origin
    function automatic logic signed [CB-1:0] rnd_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return CB'($signed($urandom_range(80)) - 40);
        if (sel < 9) return CB'($urandom);
        return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endfunction

    // drive one request and wait for its acceptance; valid stays high
    // between back-to-back requests and drops only during a gap
    task automatic send_pair(logic k1, logic signed [CB-1:0] l1, t1, r1, b1,
                             logic k2, logic signed [CB-1:0] l2, t2, r2, b2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_first_kind <= k1; s_first_left <= l1; s_first_top <= t1;
        s_first_right <= r1; s_first_bottom <= b1;
        s_second_kind <= k2; s_second_left <= l2; s_second_top <= t2;
        s_second_right <= r2; s_second_bottom <= b2;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic signed [CB-1:0] l1, t1, l2, t2;
        int w, h, m;
        if ($urandom_range(3) == 0) begin
            send_pair(1'($urandom), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      1'($urandom), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        end else begin
            // boxes with no reversed edges, the second possibly zero-sized; ellipse pairs often share an aspect ratio
            l1 = CB'($signed($urandom_range(60)) - 30);
            t1 = CB'($signed($urandom_range(60)) - 30);
            l2 = CB'($signed($urandom_range(60)) - 30);
            t2 = CB'($signed($urandom_range(60)) - 30);
            w = $urandom_range(1, 20); h = $urandom_range(1, 20);
            m = $urandom_range(1, 3);
            if ($urandom_range(1))
                send_pair(1'($urandom), l1, t1, CB'(l1 + w), CB'(t1 + h),
                          1'($urandom), l2, t2, CB'(l2 + w * m), CB'(t2 + h * m));
            else
                send_pair(1'($urandom), l1, t1, CB'(l1 + w), CB'(t1 + h),
                          1'($urandom), l2, t2,
                          CB'(l2 + $signed($urandom_range(0, 20))),
                          CB'(t2 + $signed($urandom_range(0, 20))));
        end
    endtask

    initial begin
        int k;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_first_kind = 0; s_first_left = 0; s_first_top = 0;
        s_first_right = 0; s_first_bottom = 0;
        s_second_kind = 0; s_second_left = 0; s_second_top = 0;
        s_second_right = 0; s_second_bottom = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: each pair kind, touching edges, reversed and zero boxes
        send_pair(KIND_RECT, 0, 0, 10, 10, KIND_RECT, 5, 5, 15, 15);
        send_pair(KIND_RECT, 0, 0, 10, 10, KIND_RECT, 10, 0, 20, 10);
        send_pair(KIND_RECT, 10, 10, 0, 0, KIND_RECT, 0, 0, 10, 10);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_RECT, 2, 2, 4, 4);
        send_pair(KIND_RECT, 4, -5, 6, 20, KIND_ELL, 0, 0, 10, 10);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_RECT, 9, 9, 20, 20);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_RECT, 10, 10, 20, 20);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_ELL, 8, 0, 18, 10);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_ELL, 10, 0, 20, 10);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_ELL, 11, 0, 21, 10);
        send_pair(KIND_ELL, 0, 0, 10, 20, KIND_ELL, 9, 0, 19, 10);
        send_pair(KIND_ELL, 0, 0, 0, 10, KIND_ELL, 0, 0, 10, 10);
        send_pair(KIND_ELL, 10, 10, 0, 0, KIND_RECT, 0, 0, 10, 10);
        send_pair(KIND_ELL, 0, 0, 10, 10, KIND_ELL, 3, 3, 6, 6);
        send_pair(KIND_RECT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  KIND_ELL, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(KIND_ELL, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  KIND_ELL, 16'sh7ffe, 16'sh7ffe, 16'sh7fff, 16'sh7fff);
        send_pair(KIND_ELL, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                  KIND_RECT, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_pair(KIND_ELL, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                  KIND_ELL, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 12; k++) send_random();
        join

        // random phases with different idling
        for (k = 0; k < 520; k++) begin
            unique case ((k / 65) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            send_random();
        end
        s_valid <= 1'b0;

        recv_stall_pct = 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
